// ===== rtl/tclp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types, character codes and recognizer codes of the command line
// parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

    localparam int unsigned LINE_LIMIT = 128;
    localparam int unsigned LEN_W      = $clog2(LINE_LIMIT + 1);
    localparam int unsigned SPEED_FULL = 100;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // head recognizer
    localparam logic [3:0] HM_EMPTY   = 4'd0;
    localparam logic [3:0] HM_L       = 4'd1;
    localparam logic [3:0] HM_LE      = 4'd2;
    localparam logic [3:0] HM_LED     = 4'd3;
    localparam logic [3:0] HM_LED_DIG = 4'd4;
    localparam logic [3:0] HM_M       = 4'd5;
    localparam logic [3:0] HM_MO      = 4'd6;
    localparam logic [3:0] HM_MOT     = 4'd7;
    localparam logic [3:0] HM_OTHER   = 4'd8;

    // tail recognizer
    localparam logic [2:0] TM_EMPTY     = 3'd0;
    localparam logic [2:0] TM_O         = 3'd1;
    localparam logic [2:0] TM_ON        = 3'd2;
    localparam logic [2:0] TM_OF        = 3'd3;
    localparam logic [2:0] TM_OFF       = 3'd4;
    localparam logic [2:0] TM_BAD       = 3'd5;
    localparam logic [2:0] TM_NUM_BLANK = 3'd1;
    localparam logic [2:0] TM_NUM_BODY  = 3'd2;
    localparam logic [2:0] TM_NONEMPTY  = 3'd1;

    // result actions
    localparam logic [2:0] ACT_INCORRECT = 3'd0;
    localparam logic [2:0] ACT_LED       = 3'd1;
    localparam logic [2:0] ACT_STOP      = 3'd2;
    localparam logic [2:0] ACT_FWD       = 3'd3;
    localparam logic [2:0] ACT_BACK      = 3'd4;
    localparam logic [2:0] ACT_NONE      = 3'd5;

    typedef struct packed {
        logic       overlong;
        logic [3:0] head;
        logic [7:0] led_digit;
        logic [2:0] tail;
        logic       negative;
        logic [6:0] magnitude;
    } t_line_status;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] led_index;
        logic       led_on;
        logic [6:0] speed_percent;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/tclp_line_state.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_line_state
// Per-line recognizer state: length count, token phase, head and tail
// matchers and the running motor number. Cleared by each newline.
// ----------------------------------------------------------------------------
module tclp_line_state (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [7:0]            i_char,
    output tclp_pkg::t_line_status     o_status
);
    import tclp_pkg::*;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_HEAD   = 4'b0010,
        PH_TAIL   = 4'b0100,
        PH_IGNORE = 4'b1000
    } t_phase;

    t_phase           r_phase,    n_phase;
    logic [LEN_W-1:0] r_len,      n_len;
    logic             r_overlong, n_overlong;
    logic [3:0]       r_head,     n_head;
    logic [7:0]       r_digit,    n_digit;
    logic [2:0]       r_tail,     n_tail;
    logic             r_neg,      n_neg;
    logic [6:0]       r_mag,      n_mag;
    logic             r_ended,    n_ended;

    logic [7:0]       c;
    logic             blank;
    logic             is_dig;
    logic [9:0]       mag_sum;
    logic             take_digit;

    function automatic logic [3:0] head_next(input logic [3:0] h, input logic [7:0] ch);
        logic [3:0] res;
        res = h;
        case (h)
            HM_EMPTY: res = (ch == CH_L) ? HM_L : (ch == CH_M) ? HM_M : HM_OTHER;
            HM_L:     res = (ch == CH_E) ? HM_LE : HM_OTHER;
            HM_LE:    res = (ch == CH_D) ? HM_LED : HM_OTHER;
            HM_LED:   res = HM_LED_DIG;
            HM_M:     res = (ch == CH_O) ? HM_MO : HM_OTHER;
            HM_MO:    res = (ch == CH_T) ? HM_MOT : HM_OTHER;
            default:  res = h;
        endcase
        return res;
    endfunction

    always_comb begin
        c = i_char;
        if (i_char >= CH_LC_A && i_char <= CH_LC_Z) begin
            c = i_char - CASE_OFS;
        end
        blank   = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_CR);
        is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        mag_sum = ({3'b000, r_mag} << 3) + ({3'b000, r_mag} << 1) + {6'b000000, c[3:0]};
        take_digit = 1'b0;

        n_phase    = r_phase;
        n_len      = r_len;
        n_overlong = r_overlong;
        n_head     = r_head;
        n_digit    = r_digit;
        n_tail     = r_tail;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_ended    = r_ended;

        if (i_step && i_char == CH_LF) begin
            n_phase    = PH_LEAD;
            n_len      = '0;
            n_overlong = 1'b0;
            n_head     = HM_EMPTY;
            n_digit    = '0;
            n_tail     = TM_EMPTY;
            n_neg      = 1'b0;
            n_mag      = '0;
            n_ended    = 1'b0;
        end else if (i_step && !blank) begin
            if (r_len >= LEN_W'(LINE_LIMIT)) begin
                n_overlong = 1'b1;
            end else begin
                n_len = r_len + 1'b1;
            end

            unique case (r_phase)
                PH_LEAD: begin
                    if (c == CH_NUL) begin
                        n_phase = PH_IGNORE;
                    end else if (c != CH_EQ) begin
                        n_phase = PH_HEAD;
                        n_head  = head_next(r_head, c);
                        if (r_head == HM_LED) n_digit = c;
                    end
                end
                PH_HEAD: begin
                    if (c == CH_NUL) begin
                        n_phase = PH_IGNORE;
                    end else if (c == CH_EQ) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_head = head_next(r_head, c);
                        if (r_head == HM_LED) n_digit = c;
                    end
                end
                PH_TAIL: begin
                    if (c == CH_NUL) begin
                        n_phase = PH_IGNORE;
                    end else if (r_head == HM_LED || r_head == HM_LED_DIG) begin
                        case (r_tail)
                            TM_EMPTY: n_tail = (c == CH_O) ? TM_O : TM_BAD;
                            TM_O:     n_tail = (c == CH_N) ? TM_ON :
                                               (c == CH_F) ? TM_OF : TM_BAD;
                            TM_OF:    n_tail = (c == CH_F) ? TM_OFF : TM_BAD;
                            default:  n_tail = TM_BAD;
                        endcase
                    end else if (r_head == HM_MOT) begin
                        if (r_tail == TM_EMPTY) n_tail = TM_NUM_BLANK;
                        if (!r_ended) begin
                            if (r_tail != TM_NUM_BODY) begin
                                // leading blanks, then an optional sign
                                if (c != CH_VT && c != CH_FF) begin
                                    n_tail = TM_NUM_BODY;
                                    if (c == CH_MINUS) begin
                                        n_neg = 1'b1;
                                    end else if (c != CH_PLUS) begin
                                        take_digit = 1'b1;
                                    end
                                end
                            end else begin
                                take_digit = 1'b1;
                            end
                            if (take_digit) begin
                                if (is_dig) begin
                                    n_mag = (mag_sum > 10'(SPEED_FULL)) ?
                                            7'(SPEED_FULL) : mag_sum[6:0];
                                end else begin
                                    n_ended = 1'b1;
                                end
                            end
                        end
                    end else begin
                        n_tail = TM_NONEMPTY;
                    end
                end
                PH_IGNORE: begin
                end
                default: begin
                    n_phase = PH_IGNORE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEAD;
            r_len      <= '0;
            r_overlong <= 1'b0;
            r_head     <= HM_EMPTY;
            r_digit    <= '0;
            r_tail     <= TM_EMPTY;
            r_neg      <= 1'b0;
            r_mag      <= '0;
            r_ended    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_overlong <= n_overlong;
            r_head     <= n_head;
            r_digit    <= n_digit;
            r_tail     <= n_tail;
            r_neg      <= n_neg;
            r_mag      <= n_mag;
            r_ended    <= n_ended;
        end
    end

    assign o_status.overlong  = r_overlong;
    assign o_status.head      = r_head;
    assign o_status.led_digit = r_digit;
    assign o_status.tail      = r_tail;
    assign o_status.negative  = r_neg;
    assign o_status.magnitude = r_mag;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(LINE_LIMIT))
        else $error("line length beyond limit");
    a_overlong_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overlong |-> (r_len == LEN_W'(LINE_LIMIT)))
        else $error("overlong flag set before line filled");
    a_speed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag <= 7'(SPEED_FULL))
        else $error("motor magnitude not saturated");
`endif

endmodule
`default_nettype wire

// ===== rtl/tclp_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_decode
// Turns the finished line status into the action, led and speed fields.
// ----------------------------------------------------------------------------
module tclp_decode (
    input  wire tclp_pkg::t_line_status i_status,
    output tclp_pkg::t_result           o_result
);
    import tclp_pkg::*;

    logic led_head;
    logic tail_ok;
    logic digit_valid;

    always_comb begin
        led_head    = (i_status.head == HM_LED) || (i_status.head == HM_LED_DIG);
        tail_ok     = (i_status.tail == TM_ON) || (i_status.tail == TM_OFF);
        digit_valid = (i_status.head == HM_LED_DIG) &&
                      (i_status.led_digit >= CH_ONE) && (i_status.led_digit <= CH_THREE);

        o_result.action        = ACT_INCORRECT;
        o_result.led_index     = 2'd0;
        o_result.led_on        = 1'b0;
        o_result.speed_percent = 7'd0;

        if (i_status.overlong || i_status.head == HM_EMPTY) begin
            o_result.action = ACT_INCORRECT;
        end else if (led_head) begin
            if (!tail_ok) begin
                o_result.action = ACT_INCORRECT;
            end else if (digit_valid) begin
                o_result.action    = ACT_LED;
                o_result.led_index = i_status.led_digit[1:0];
                o_result.led_on    = (i_status.tail == TM_ON);
            end else if (i_status.head == HM_LED_DIG && i_status.led_digit == CH_ZERO) begin
                o_result.action = ACT_INCORRECT;
            end else begin
                o_result.action = ACT_NONE;
            end
        end else if (i_status.head == HM_MOT) begin
            if (i_status.tail == TM_EMPTY || i_status.magnitude == 7'd0) begin
                o_result.action = ACT_STOP;
            end else begin
                o_result.action        = i_status.negative ? ACT_BACK : ACT_FWD;
                o_result.speed_percent = i_status.magnitude;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/text_command_line_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_command_line_parser
// Character-by-character command line parser for LED and motor commands.
// A newline request reaches the output through the input register, then
//   the result register.
// Throughput: one character per cycle; a newline waits in the input register
//   only while a previous result is still stalled.
// Reset: synchronous active-low; clears line state and both valid flags.
// ----------------------------------------------------------------------------
module text_command_line_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_char,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_action,
    output logic [1:0]      o_led_index,
    output logic            o_led_on,
    output logic [6:0]      o_speed_percent
);
    import tclp_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_out_valid;
    t_result      r_out;

    logic         in_is_nl;
    logic         out_free;
    logic         proceed;
    logic         accept;
    t_line_status status;
    t_result      result;

    assign in_is_nl = (r_in_char == CH_LF);
    assign out_free = !r_out_valid || !i_stall;
    // only a newline needs the result slot; other characters always advance
    assign proceed  = r_in_valid && (!in_is_nl || out_free);
    assign o_stall  = r_in_valid && !proceed;
    assign accept   = i_valid && !o_stall;

    tclp_line_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (proceed),
        .i_char   (r_in_char),
        .o_status (status)
    );

    tclp_decode u_decode (
        .i_status (status),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_rx_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && in_is_nl) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && in_is_nl) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_action        = r_out.action;
    assign o_led_index     = r_out.led_index;
    assign o_led_on        = r_out.led_on;
    assign o_speed_percent = r_out.speed_percent;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && in_is_nl && r_out_valid))
        else $error("input stalled without a blocked newline");
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");
    a_result_from_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proceed && in_is_nl))
        else $error("result raised without a newline");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command line parser. It streams directed and
// randomized command lines with random request gaps and result stalls. A
// scoreboard decodes each line in software and checks every result field.
// ----------------------------------------------------------------------------
module tb_top;
    import tclp_pkg::*;

    localparam int         CHAR_TARGET  = 1650;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES = 16;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_Z      = 8'h5A;

    typedef enum logic [1:0] {PH_LEAD_EQ, PH_HEAD, PH_TAIL, PH_IGNORE} t_line_phase;

    class command_line_tracker;
        t_result     awaited[$];
        int          failures;
        int          chars_taken;
        int          results_checked;
        int          action_seen[6];
        int unsigned stored_len;
        bit          overlong;
        t_line_phase phase;
        logic [3:0]  head;
        logic [7:0]  led_digit;
        logic [2:0]  tail;
        bit          negative;
        int          magnitude;
        bit          ended;

        function new();
            failures        = 0;
            chars_taken     = 0;
            results_checked = 0;
            foreach (action_seen[k])
                action_seen[k] = 0;
            clear_line();
        endfunction

        function void clear_line();
            stored_len = 0;
            overlong   = 1'b0;
            phase      = PH_LEAD_EQ;
            head       = HM_EMPTY;
            led_digit  = CH_NUL;
            tail       = TM_EMPTY;
            negative   = 1'b0;
            magnitude  = 0;
            ended      = 1'b0;
        endfunction

        function void note_char(logic [7:0] raw);
            logic [7:0] c;
            t_result    res;
            int         v;
            bit         skip;
            c = raw;
            chars_taken++;
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
                return;
            if (c == CH_LF) begin
                res        = '0;
                res.action = ACT_INCORRECT;
                if (!overlong && (head == HM_LED || head == HM_LED_DIG)) begin
                    if (tail == TM_ON || tail == TM_OFF) begin
                        if (head == HM_LED_DIG && led_digit >= CH_ONE
                                && led_digit <= CH_THREE) begin
                            res.action    = ACT_LED;
                            res.led_index = 2'(led_digit - CH_ZERO);
                            res.led_on    = (tail == TM_ON);
                        end else if (!(head == HM_LED_DIG && led_digit == CH_ZERO)) begin
                            res.action = ACT_NONE;
                        end
                    end
                end else if (!overlong && head == HM_MOT) begin
                    if (tail == TM_EMPTY || magnitude == 0) begin
                        res.action = ACT_STOP;
                    end else begin
                        res.action        = negative ? ACT_BACK : ACT_FWD;
                        res.speed_percent = 7'(magnitude);
                    end
                end
                awaited.push_back(res);
                action_seen[res.action]++;
                clear_line();
                return;
            end
            if (c >= CH_LC_A && c <= CH_LC_Z)
                c = c - CASE_OFS;
            if (stored_len >= LINE_LIMIT)
                overlong = 1'b1;
            else
                stored_len++;
            if (phase == PH_IGNORE)
                return;
            // a NUL terminates the line text, the rest is only counted
            if (c == CH_NUL) begin
                phase = PH_IGNORE;
                return;
            end
            if (phase == PH_LEAD_EQ) begin
                if (c == CH_EQ)
                    return;
                phase = PH_HEAD;
            end
            if (phase == PH_HEAD) begin
                if (c == CH_EQ) begin
                    phase = PH_TAIL;
                    return;
                end
                case (head)
                    HM_EMPTY: head = (c == CH_L) ? HM_L : (c == CH_M) ? HM_M : HM_OTHER;
                    HM_L:     head = (c == CH_E) ? HM_LE : HM_OTHER;
                    HM_LE:    head = (c == CH_D) ? HM_LED : HM_OTHER;
                    HM_LED: begin
                        led_digit = c;
                        head      = HM_LED_DIG;
                    end
                    HM_M:     head = (c == CH_O) ? HM_MO : HM_OTHER;
                    HM_MO:    head = (c == CH_T) ? HM_MOT : HM_OTHER;
                    default:  ;
                endcase
                return;
            end
            if (head == HM_LED || head == HM_LED_DIG) begin
                case (tail)
                    TM_EMPTY: tail = (c == CH_O) ? TM_O : TM_BAD;
                    TM_O:     tail = (c == CH_N) ? TM_ON : (c == CH_F) ? TM_OF : TM_BAD;
                    TM_OF:    tail = (c == CH_F) ? TM_OFF : TM_BAD;
                    default:  tail = TM_BAD;
                endcase
            end else if (head == HM_MOT) begin
                if (tail == TM_EMPTY)
                    tail = TM_NUM_BLANK;
                if (!ended) begin
                    skip = 1'b0;
                    if (tail == TM_NUM_BLANK) begin
                        if (c == CH_VT || c == CH_FF) begin
                            skip = 1'b1;
                        end else begin
                            tail = TM_NUM_BODY;
                            if (c == CH_PLUS) begin
                                skip = 1'b1;
                            end else if (c == CH_MINUS) begin
                                negative = 1'b1;
                                skip     = 1'b1;
                            end
                        end
                    end
                    if (!skip) begin
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            v         = magnitude * 10 + int'(c - CH_ZERO);
                            magnitude = (v > SPEED_FULL) ? SPEED_FULL : v;
                        end else begin
                            ended = 1'b1;
                        end
                    end
                end
            end else begin
                tail = TM_NONEMPTY;
            end
        endfunction

        function void check_action(logic [2:0] action, logic [1:0] led_index,
                                   logic led_on, logic [6:0] speed_percent);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result with no command line pending: action %0d", action);
                failures++;
                return;
            end
            want = awaited.pop_front();
            results_checked++;
            if (action !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, action);
                failures++;
            end
            if (led_index !== want.led_index) begin
                $error("led_index: expected %0d, got %0d", want.led_index, led_index);
                failures++;
            end
            if (led_on !== want.led_on) begin
                $error("led_on: expected %0d, got %0d", want.led_on, led_on);
                failures++;
            end
            if (speed_percent !== want.speed_percent) begin
                $error("speed_percent: expected %0d, got %0d",
                       want.speed_percent, speed_percent);
                failures++;
            end
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_char = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_action;
    logic [1:0] o_led_index;
    logic       o_led_on;
    logic [6:0] o_speed_percent;

    bit                  calm        = 1'b0;
    int                  stall_left  = 0;
    int                  idle_cycles = 0;
    logic [7:0]          line_buf[$];
    command_line_tracker tracker     = new();

    text_command_line_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_char       (i_rx_char),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_action        (o_action),
        .o_led_index     (o_led_index),
        .o_led_on        (o_led_on),
        .o_speed_percent (o_speed_percent)
    );

    always #2 i_clk = ~i_clk;

    // mostly short gaps, a few long ones; none at all while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_char(logic [7:0] c, bit vary);
        int k;
        if (vary && $urandom_range(0, 11) == 0) begin
            k = $urandom_range(0, 2);
            line_buf.push_back(k == 0 ? CH_SPACE : k == 1 ? CH_TAB : CH_CR);
        end
        if (vary && c >= CH_UC_A && c <= CH_UC_Z && $urandom_range(0, 2) == 0)
            c = c + CASE_OFS;
        line_buf.push_back(c);
    endfunction

    function automatic void add_text(string s, bit vary);
        for (int k = 0; k < s.len(); k++)
            add_char(s[k], vary);
    endfunction

    function automatic void add_noise(int n);
        repeat (n)
            line_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_random_line();
        int    pick;
        int    total;
        string stub;
        pick = $urandom_range(0, 99);
        if (pick < 98 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                add_char(CH_EQ, 1);
        if (pick < 35) begin
            add_text("LED", 1);
            case ($urandom_range(0, 9))
                0:       ;
                1:       add_char(8'($urandom_range(0, 255)), 1);
                2:       add_char(8'(CH_ZERO + $urandom_range(4, 9)), 1);
                default: add_char(8'(CH_ZERO + $urandom_range(0, 3)), 1);
            endcase
            if ($urandom_range(0, 7) == 0)
                add_noise(1);
            if ($urandom_range(0, 15) != 0)
                add_char(CH_EQ, 1);
            case ($urandom_range(0, 7))
                0, 1, 2: add_text("ON", 1);
                3, 4, 5: add_text("OFF", 1);
                6: begin
                    case ($urandom_range(0, 5))
                        0:       stub = "O";
                        1:       stub = "OF";
                        2:       stub = "ONX";
                        3:       stub = "OFFF";
                        4:       stub = "ON=";
                        default: stub = "";
                    endcase
                    add_text(stub, 1);
                end
                default: add_noise($urandom_range(1, 4));
            endcase
        end else if (pick < 70) begin
            add_text("MOT", 1);
            if ($urandom_range(0, 5) == 0)
                add_text("OR", 1);
            if ($urandom_range(0, 9) != 0) begin
                add_char(CH_EQ, 1);
                if ($urandom_range(0, 4) == 0)
                    add_char($urandom_range(0, 1) ? CH_VT : CH_FF, 0);
                case ($urandom_range(0, 3))
                    0:       add_char(CH_PLUS, 1);
                    1:       add_char(CH_MINUS, 1);
                    default: ;
                endcase
                case ($urandom_range(0, 9))
                    0:       stub = "";
                    1:       stub = $sformatf("%0d", $urandom_range(101, 99999));
                    2:       stub = $sformatf("%03d", $urandom_range(0, 100));
                    default: stub = $sformatf("%0d", $urandom_range(0, 110));
                endcase
                add_text(stub, 1);
                if ($urandom_range(0, 3) == 0)
                    add_noise($urandom_range(1, 4));
            end
        end else if (pick < 80) begin
            case ($urandom_range(0, 6))
                0:       stub = "L";
                1:       stub = "LE";
                2:       stub = "LEX";
                3:       stub = "M";
                4:       stub = "MO";
                5:       stub = "MX";
                default: stub = "X9";
            endcase
            add_text(stub, 1);
            if ($urandom_range(0, 1) == 0)
                add_text("=ON", 1);
        end else if (pick < 90) begin
            add_noise($urandom_range(1, 12));
        end else if (pick < 96) begin
            case ($urandom_range(0, 2))
                0: begin
                    add_char(CH_NUL, 0);
                    add_text("LED1=ON", 1);
                end
                1: begin
                    add_text("MOT=4", 1);
                    add_char(CH_NUL, 0);
                    add_text("7", 1);
                end
                default: begin
                    add_text("LED2=O", 1);
                    add_char(CH_NUL, 0);
                    add_text("N", 1);
                end
            endcase
        end else if (pick < 98) begin
            // a lone '=' leaves the head empty; with ON after it, ON becomes the head
            add_char(CH_EQ, 1);
            if ($urandom_range(0, 1) == 0)
                add_text("ON", 1);
        end else begin
            // pad a valid command with leading '=' up to around the length limit
            total = $urandom_range(LINE_LIMIT - 1, LINE_LIMIT + 2);
            repeat (total - 7)
                line_buf.push_back(CH_EQ);
            add_text("LED2=ON", 1);
        end
        add_char(CH_LF, 0);
    endfunction

    task automatic send_char(logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_char <= ch;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        tracker.note_char(ch);
    endtask

    task automatic send_queued();
        foreach (line_buf[k])
            send_char(line_buf[k]);
        line_buf.delete();
    endtask

    // result side: check, then stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_action(o_action, o_led_index, o_led_on, o_speed_percent);
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= 1'b0;
            stall_left <= pick_gap();
        end
        if ($urandom_range(0, 399) == 0)
            calm <= ~calm;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $error("no request or result accepted for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // led off, saturated backward, empty head, motor with no tail
        add_text("led3=OFF\nMOT=-250\n==\nMOT\n", 0);
        send_queued();
        while (tracker.chars_taken < CHAR_TARGET) begin
            build_random_line();
            send_queued();
        end
        i_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d characters sent, %0d command lines decoded and checked",
                 tracker.chars_taken, tracker.results_checked);
        $display("led set %0d, stop %0d, forward %0d, backward %0d, no action %0d, rejected %0d",
                 tracker.action_seen[ACT_LED], tracker.action_seen[ACT_STOP],
                 tracker.action_seen[ACT_FWD], tracker.action_seen[ACT_BACK],
                 tracker.action_seen[ACT_NONE], tracker.action_seen[ACT_INCORRECT]);
        if (tracker.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
